@@ sv/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Sampled-value frame parser package
// Shared sizes, packing widths, protocol byte codes and request kinds.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int MAX_STREAMS     = 8;
  localparam int MAX_ID_BYTES    = 128;
  localparam int MAX_CHANNELS    = 8;
  localparam int MAX_SAMPLES     = 4096;
  localparam int MAX_FRAME_BYTES = 2048;

  localparam int SID_W   = $clog2(MAX_STREAMS);
  localparam int IDPOS_W = $clog2(MAX_ID_BYTES);
  localparam int ROW_W   = MAX_STREAMS * 8;
  localparam int CNT_W   = 13;
  localparam int CHN_W   = 4;
  localparam int BPOS_W  = $clog2(MAX_FRAME_BYTES);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // protocol byte codes
  localparam logic [7:0] ETYPE_SV_HI = 8'h88;
  localparam logic [7:0] ETYPE_SV_LO = 8'hBA;
  localparam logic [7:0] ETYPE_VLAN  = 8'h81;
  localparam logic [7:0] BER_LEN_1B  = 8'h81;
  localparam logic [7:0] BER_LEN_2B  = 8'h82;
  localparam logic [7:0] TAG_DATA    = 8'h87;
  localparam logic [7:0] TAG_SVID    = 8'h80;

  typedef enum logic [1:0] {
    ACT_FRAME   = 2'd0,
    ACT_ID_WR   = 2'd1,
    ACT_CFG_WR  = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef struct packed {
    logic               asdu_last;
    logic [3:0]         full_cnt;
    logic               stream_full;
    logic signed [31:0] value;
    logic [11:0]        sample;
    logic [2:0]         chan;
    logic [2:0]         stream;
  } res_t;

endpackage

@@ sv/sampled_value_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// Sampled-value frame parser, top level
// Parses raw Ethernet frame bytes of sampled-value frames, matches the svId
// against a loaded stream table and emits one request per channel value.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in_     | slave     | in_tvalid/in_tready   | tdata, tuser=action, tlast
//  out_    | master    | out_tvalid/out_tready | tdata, tlast=asdu_last
//  cfg_    | slave     | cfg_valid/cfg_ready   | cfg_data=active_streams
//
//  One input request is taken per clock while in_tready is high; all parsing
//  for it is done in the cycle it is accepted and its result lands in the
//  output register, or in the skid register behind it if the output is held.
//  The skid register keeps input flowing while a result waits; outside the
//  sweep, in_tready drops only while the skid register is occupied.
//  rst_n is synchronous; after reset the svId table is swept to zero, one
//  row a cycle over all MAX_ID_BYTES (128) rows, with in_tready held low.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module sampled_value_frame_parser_top
  import sfp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // data_byte[7:0], stream_sel[10:8], id_position[17:11],
  // channel_count[21:18], samples_wanted[34:22], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]             in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // stream_index[2:0], channel_index[5:3], sample_index[17:6],
  // sample_value[49:18], stream_full[50], streams_full_count[54:51]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [3:0]             cfg_data
);

  typedef enum logic [4:0] {
    PH_ETH, PH_VLAN_SKIP, PH_TYPE_HI, PH_TYPE_LO, PH_HDR_SKIP, PH_PDU_LEN,
    PH_PDU_SKIP, PH_NOASDU, PH_SEQ_TAG, PH_SEQ_LEN, PH_SEQ_SKIP, PH_ASDU_TAG,
    PH_ASDU_LEN, PH_ASDU_SKIP, PH_FLD_TAG, PH_FLD_LEN, PH_FLD_SKIP, PH_ID_LEN,
    PH_ID_BYTE, PH_DATA_LEN, PH_DATA, PH_DONE
  } phase_t;

  // lowest set bit wins
  function automatic logic [SID_W-1:0] first_set(input logic [MAX_STREAMS-1:0] m);
    logic [SID_W-1:0] idx;
    idx = '0;
    for (int s = MAX_STREAMS - 1; s >= 0; s--) begin
      if (m[s]) idx = SID_W'(s);
    end
    return idx;
  endfunction

  // unpack the input request
  action_t          act;
  logic [7:0]       b;
  logic [SID_W-1:0] sel;
  logic [IDPOS_W-1:0] idpos;
  logic [CHN_W-1:0] chans_in;
  logic [CNT_W-1:0] want_in;
  logic             in_fire;

  assign act      = action_t'(in_tuser);
  assign b        = in_tdata[7:0];
  assign sel      = in_tdata[10:8];
  assign idpos    = in_tdata[17:11];
  assign chans_in = in_tdata[21:18];
  assign want_in  = in_tdata[34:22];

  // state
  phase_t                  phase_r, phase_nxt;
  logic [BPOS_W-1:0]       bpos_r, bpos_nxt;
  logic [7:0]              asdu_r, asdu_nxt;
  logic [7:0]              fbl_r, fbl_nxt;
  logic [MAX_STREAMS-1:0]  mask_r, mask_nxt;
  logic [7:0]              dlen_r, dlen_nxt;
  logic [7:0]              doff_r, doff_nxt;
  logic [7:0]              idp_r, idp_nxt;
  logic [SID_W-1:0]        matched_r, matched_nxt;
  logic                    mvalid_r, mvalid_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic [3:0]              fsc_r, fsc_nxt;
  logic [3:0]              active_r;
  logic [CHN_W-1:0]        chans_r [MAX_STREAMS];
  logic [CHN_W-1:0]        chans_nxt [MAX_STREAMS];
  logic [CNT_W-1:0]        limit_r [MAX_STREAMS];
  logic [CNT_W-1:0]        limit_nxt [MAX_STREAMS];
  logic [CNT_W-1:0]        cnt_r [MAX_STREAMS];
  logic [CNT_W-1:0]        cnt_nxt [MAX_STREAMS];

  // svId table: one row per character position, one byte lane per stream
  logic [ROW_W-1:0]        id_mem [MAX_ID_BYTES];
  logic [ROW_W-1:0]        rdata_r;
  logic                    clearing_r;
  logic [IDPOS_W-1:0]      clr_idx_r;
  logic                    wr_en;
  logic [IDPOS_W-1:0]      wr_row;
  logic [MAX_STREAMS-1:0]  wr_be;
  logic [ROW_W-1:0]        wr_data;
  logic [IDPOS_W-1:0]      rd_row;

  // output register and skid
  res_t res, out_r, skid_r;
  logic res_valid, out_valid_r, skid_valid_r;

  // finish helpers
  logic [CNT_W-1:0] cnt_inc;
  logic             fin_full;
  logic [3:0]       fsc_inc;

  assign in_tready = !clearing_r && !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign cnt_inc  = cnt_r[matched_r] + CNT_W'(1);
  assign fin_full = cnt_inc >= limit_r[matched_r];
  assign fsc_inc  = (fsc_r == 4'd15) ? fsc_r : fsc_r + 4'd1;

  always_comb begin
    logic             resolve, nxt_asdu, finish, emit, last_slot;
    logic [2:0]       slot_byte;
    logic [7:0]       fbl_dec;
    logic [31:0]      acc_new, value;
    logic [SID_W-1:0] fs;
    logic [7:0]       want;

    phase_nxt   = phase_r;
    bpos_nxt    = bpos_r;
    asdu_nxt    = asdu_r;
    fbl_nxt     = fbl_r;
    mask_nxt    = mask_r;
    dlen_nxt    = dlen_r;
    doff_nxt    = doff_r;
    idp_nxt     = idp_r;
    matched_nxt = matched_r;
    mvalid_nxt  = mvalid_r;
    acc_nxt     = acc_r;
    fsc_nxt     = fsc_r;
    chans_nxt   = chans_r;
    limit_nxt   = limit_r;
    cnt_nxt     = cnt_r;
    res_valid   = 1'b0;
    res         = '0;
    resolve     = 1'b0;
    nxt_asdu    = 1'b0;
    finish      = 1'b0;
    emit        = 1'b0;
    last_slot   = 1'b0;
    slot_byte   = doff_r[2:0];
    fbl_dec     = fbl_r - 8'd1;
    acc_new     = (slot_byte == 3'd0) ? {24'd0, b} : {acc_r[23:0], b};
    value       = '0;
    fs          = '0;
    want        = '0;
    wr_en       = 1'b0;
    wr_row      = idpos;
    wr_be       = '0;
    wr_data     = {MAX_STREAMS{b}};

    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_row  = clr_idx_r;
      wr_be   = '1;
      wr_data = '0;
    end

    if (in_fire) begin
      case (act)
        ACT_ID_WR: begin
          wr_en = 1'b1;
          wr_be = MAX_STREAMS'(1) << sel;
        end
        ACT_CFG_WR: begin
          chans_nxt[sel] = (chans_in > CHN_W'(MAX_CHANNELS)) ? CHN_W'(MAX_CHANNELS)
                                                               : chans_in;
          limit_nxt[sel] = (want_in > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                             : want_in;
        end
        ACT_RESTART: begin
          for (int s = 0; s < MAX_STREAMS; s++) cnt_nxt[s] = '0;
          fsc_nxt = '0;
        end
        default: begin
          if (bpos_r >= BPOS_W'(MAX_FRAME_BYTES - 1)) begin
            phase_nxt = PH_DONE;
          end else begin
            bpos_nxt = bpos_r + BPOS_W'(1);
            case (phase_r)
              PH_ETH: begin
                if (bpos_r == BPOS_W'(12)) begin
                  acc_nxt = {24'd0, b};
                end else if (bpos_r == BPOS_W'(13)) begin
                  if (acc_r == {24'd0, ETYPE_VLAN} && b == 8'h00) begin
                    fbl_nxt = 8'd2; phase_nxt = PH_VLAN_SKIP;
                  end else if (acc_r == {24'd0, ETYPE_SV_HI} && b == ETYPE_SV_LO) begin
                    fbl_nxt = 8'd9; phase_nxt = PH_HDR_SKIP;
                  end else begin
                    phase_nxt = PH_DONE;
                  end
                end
              end
              PH_VLAN_SKIP, PH_HDR_SKIP, PH_PDU_SKIP, PH_ASDU_SKIP, PH_FLD_SKIP: begin
                if (fbl_r != 8'd0) fbl_nxt = fbl_dec;
                if (fbl_r <= 8'd1) begin
                  case (phase_r)
                    PH_VLAN_SKIP: phase_nxt = PH_TYPE_HI;
                    PH_HDR_SKIP:  phase_nxt = PH_PDU_LEN;
                    PH_PDU_SKIP:  phase_nxt = PH_NOASDU;
                    default:      phase_nxt = PH_FLD_TAG;
                  endcase
                end
              end
              PH_TYPE_HI: begin
                acc_nxt   = {24'd0, b};
                phase_nxt = PH_TYPE_LO;
              end
              PH_TYPE_LO: begin
                if (acc_r == {24'd0, ETYPE_SV_HI} && b == ETYPE_SV_LO) begin
                  fbl_nxt = 8'd9; phase_nxt = PH_HDR_SKIP;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              PH_PDU_LEN: begin
                fbl_nxt   = (b == BER_LEN_2B) ? 8'd4 : (b == BER_LEN_1B) ? 8'd3 : 8'd2;
                phase_nxt = PH_PDU_SKIP;
              end
              PH_NOASDU: begin
                asdu_nxt  = b;
                phase_nxt = PH_SEQ_TAG;
              end
              PH_SEQ_TAG: phase_nxt = PH_SEQ_LEN;
              PH_SEQ_LEN: begin
                if (b == BER_LEN_2B) begin
                  fbl_nxt = 8'd2; phase_nxt = PH_SEQ_SKIP;
                end else if (b == BER_LEN_1B) begin
                  fbl_nxt = 8'd1; phase_nxt = PH_SEQ_SKIP;
                end else begin
                  nxt_asdu = 1'b1;
                end
              end
              PH_SEQ_SKIP: begin
                if (fbl_r != 8'd0) fbl_nxt = fbl_dec;
                if (fbl_r <= 8'd1) nxt_asdu = 1'b1;
              end
              PH_ASDU_TAG: phase_nxt = PH_ASDU_LEN;
              PH_ASDU_LEN: begin
                fbl_nxt   = (b == BER_LEN_2B) ? 8'd2 : (b == BER_LEN_1B) ? 8'd1 : 8'd0;
                phase_nxt = (b == BER_LEN_2B || b == BER_LEN_1B) ? PH_ASDU_SKIP
                                                                 : PH_FLD_TAG;
              end
              PH_FLD_TAG: begin
                if (b == TAG_DATA)                  phase_nxt = PH_DATA_LEN;
                else if (b == TAG_SVID && !mvalid_r) phase_nxt = PH_ID_LEN;
                else                                phase_nxt = PH_FLD_LEN;
              end
              PH_FLD_LEN: begin
                fbl_nxt   = b;
                phase_nxt = (b == 8'd0) ? PH_FLD_TAG : PH_FLD_SKIP;
              end
              PH_ID_LEN: begin
                // arm every active stream, then knock out mismatches
                for (int s = 0; s < MAX_STREAMS; s++) mask_nxt[s] = active_r > 4'(s);
                acc_nxt = {24'd0, b};
                fbl_nxt = b;
                idp_nxt = '0;
                if (b == 8'd0) resolve = 1'b1;
                else           phase_nxt = PH_ID_BYTE;
              end
              PH_ID_BYTE: begin
                for (int s = 0; s < MAX_STREAMS; s++) begin
                  want = (idp_r < 8'(MAX_ID_BYTES)) ? rdata_r[8*s +: 8] : 8'd0;
                  if (want != b) mask_nxt[s] = 1'b0;
                end
                idp_nxt = idp_r + 8'd1;
                fbl_nxt = fbl_dec;
                if (fbl_dec == 8'd0) resolve = 1'b1;
              end
              PH_DATA_LEN: begin
                if (!mvalid_r || b > {1'b0, chans_r[matched_r], 3'b000}) begin
                  phase_nxt = PH_DONE;
                end else if (b == 8'd0) begin
                  finish = 1'b1;
                  if (fin_full) phase_nxt = PH_DONE;
                  else          nxt_asdu  = 1'b1;
                end else begin
                  dlen_nxt  = b;
                  fbl_nxt   = b;
                  acc_nxt   = '0;
                  doff_nxt  = '0;
                  phase_nxt = PH_DATA;
                end
              end
              PH_DATA: begin
                fbl_nxt  = fbl_dec;
                doff_nxt = doff_r + 8'd1;
                if (slot_byte < 3'd4) acc_nxt = acc_new;
                emit = (slot_byte == 3'd3) || (slot_byte < 3'd3 && fbl_dec == 8'd0);
                if (emit) begin
                  last_slot = doff_r[7:3] == 5'((dlen_r - 8'd1) >> 3);
                  case (slot_byte[1:0])
                    2'd0:    value = acc_new << 24;
                    2'd1:    value = acc_new << 16;
                    2'd2:    value = acc_new << 8;
                    default: value = acc_new;
                  endcase
                  res_valid       = 1'b1;
                  res.stream      = 3'(matched_r);
                  res.chan        = doff_r[5:3];
                  res.sample      = cnt_r[matched_r][11:0];
                  res.value       = value;
                  res.asdu_last   = last_slot;
                  res.stream_full = last_slot && fin_full;
                  res.full_cnt    = (last_slot && fin_full) ? fsc_inc : fsc_r;
                  finish          = last_slot;
                end
                if (emit && last_slot && fin_full) phase_nxt = PH_DONE;
                else if (fbl_dec == 8'd0)          nxt_asdu  = 1'b1;
              end
              default: ;
            endcase

            if (nxt_asdu) begin
              if (asdu_r == 8'd0) begin
                phase_nxt = PH_DONE;
              end else begin
                asdu_nxt  = asdu_r - 8'd1;
                phase_nxt = PH_ASDU_TAG;
              end
            end
            if (resolve) begin
              phase_nxt = PH_FLD_TAG;
              fs        = first_set(mask_nxt);
              if (|mask_nxt) begin
                matched_nxt = fs;
                mvalid_nxt  = 1'b1;
                if (cnt_r[fs] >= limit_r[fs]) phase_nxt = PH_DONE;
              end
            end
            if (finish) begin
              cnt_nxt[matched_r] = cnt_inc;
              if (fin_full) fsc_nxt = fsc_inc;
            end
          end
          // drop all frame context after the final byte
          if (in_tlast) begin
            bpos_nxt    = '0;
            phase_nxt   = PH_ETH;
            asdu_nxt    = '0;
            fbl_nxt     = '0;
            mask_nxt    = '0;
            dlen_nxt    = '0;
            matched_nxt = '0;
            mvalid_nxt  = 1'b0;
            acc_nxt     = '0;
            idp_nxt     = '0;
          end
        end
      endcase
    end
  end

  assign rd_row = idp_nxt[IDPOS_W-1:0];

  // table write, registered read with write forwarding per byte lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int s = 0; s < MAX_STREAMS; s++) begin
        if (wr_be[s]) id_mem[wr_row][8*s +: 8] <= wr_data[8*s +: 8];
      end
    end
    for (int s = 0; s < MAX_STREAMS; s++) begin
      if (wr_en && wr_be[s] && wr_row == rd_row) rdata_r[8*s +: 8] <= wr_data[8*s +: 8];
      else                                      rdata_r[8*s +: 8] <= id_mem[rd_row][8*s +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ETH;
      bpos_r       <= '0;
      asdu_r       <= '0;
      fbl_r        <= '0;
      mask_r       <= '0;
      dlen_r       <= '0;
      doff_r       <= '0;
      idp_r        <= '0;
      matched_r    <= '0;
      mvalid_r     <= 1'b0;
      acc_r        <= '0;
      fsc_r        <= '0;
      active_r     <= '0;
      clearing_r   <= 1'b1;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int s = 0; s < MAX_STREAMS; s++) begin
        chans_r[s] <= CHN_W'(1);
        limit_r[s] <= CNT_W'(1);
        cnt_r[s]   <= '0;
      end
    end else begin
      phase_r   <= phase_nxt;
      bpos_r    <= bpos_nxt;
      asdu_r    <= asdu_nxt;
      fbl_r     <= fbl_nxt;
      mask_r    <= mask_nxt;
      dlen_r    <= dlen_nxt;
      doff_r    <= doff_nxt;
      idp_r     <= idp_nxt;
      matched_r <= matched_nxt;
      mvalid_r  <= mvalid_nxt;
      acc_r     <= acc_nxt;
      fsc_r     <= fsc_nxt;
      chans_r   <= chans_nxt;
      limit_r   <= limit_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_valid && cfg_ready) active_r <= cfg_data;
      // sweep the table once after reset
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + IDPOS_W'(1);
        if (clr_idx_r == IDPOS_W'(MAX_ID_BYTES - 1)) clearing_r <= 1'b0;
      end
      // output register with skid behind it
      if (out_valid_r && out_tready) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_r       <= res;
          out_valid_r <= res_valid;
        end
      end else if (!out_valid_r) begin
        out_r       <= res;
        out_valid_r <= res_valid;
      end else if (res_valid) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.asdu_last;
  assign out_tdata  = {1'b0, out_r.full_cnt, out_r.stream_full, out_r.value,
                       out_r.sample, out_r.chan, out_r.stream};

  // a held result always sits behind a valid output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds a result with output empty");

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready) else $error("input taken during table sweep");

  a_id_only_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ID_BYTE) |-> !mvalid_r) else $error("svId compare after match");

  a_data_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> mvalid_r) else $error("data field walked without a match");

  a_result_only_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == PH_DATA && in_fire)) else $error("stray result");

endmodule
